[sv/iss_pkg.sv]
// Package for the integer set stack with search.
// Holds operation codes, error codes, controller commands and the status struct.
// No dependencies.
package iss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int MODE_W    = 3;
  localparam int ERR_W     = 2;

  localparam logic [MODE_W-1:0] MODE_ADD    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TEST   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_POPCAP,
    CMD_SCAN,
    CMD_SHIFT,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic scan_last;
    logic shift_last;
    logic remove;
    logic out_free;
  } status_t;

endpackage

[sv/iss_if.sv]
// Channel interfaces for the integer set stack: request and response.
// Depends on iss_pkg for field widths.
interface iss_req_if;
  logic                                    valid;
  logic                                    ready;
  logic [iss_pkg::MODE_W-1:0]              mode;
  logic signed [iss_pkg::DATA_W-1:0]       value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

interface iss_rsp_if #(
  parameter int CW = 5
);
  logic                                    valid;
  logic                                    ready;
  logic                                    is_member;
  logic signed [iss_pkg::DATA_W-1:0]       popped_value;
  logic                                    now_empty;
  logic [CW-1:0]                           entry_count;
  logic [iss_pkg::ERR_W-1:0]               error_code;

  modport source (output valid, is_member, popped_value, now_empty, entry_count, error_code,
                  input ready);
  modport sink   (input valid, is_member, popped_value, now_empty, entry_count, error_code,
                  output ready);
endinterface

[sv/iss_dp.sv]
// Datapath: value memory, fill count, scan/shift index and result registers.
// Driven by commands from iss_ctrl; depends on iss_pkg.
module iss_dp #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  iss_pkg::cmd_t                      cmd,
  output iss_pkg::status_t                   st,
  input  logic [iss_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [iss_pkg::DATA_W-1:0]  in_value,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_member,
  output logic signed [iss_pkg::DATA_W-1:0]  out_popped,
  output logic                               out_empty,
  output logic [CW-1:0]                      out_count,
  output logic [iss_pkg::ERR_W-1:0]          out_error
);
  import iss_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic [CW-1:0]            fill;
  logic [AW-1:0]            cidx;
  logic signed [DATA_W-1:0] val;
  logic [MODE_W-1:0]        mode;
  logic                     r_member;
  logic signed [DATA_W-1:0] r_popped;
  logic [ERR_W-1:0]         r_err;

  logic [CW-1:0]            fill_m1;
  logic [CW-1:0]            cidx_p1;
  logic                     match;
  logic                     full;
  logic                     empty;
  logic                     shift_last;

  assign fill_m1    = fill - CW'(1);
  assign cidx_p1    = CW'(cidx) + CW'(1);
  assign match      = (rd_data == val);
  assign full       = (fill == CW'(DEPTH));
  assign empty      = (fill == '0);
  assign shift_last = (cidx_p1 >= fill);

  always_comb begin
    st.empty      = empty;
    st.hit        = match;
    st.scan_last  = (cidx == '0);
    st.shift_last = shift_last;
    st.remove     = (mode == MODE_REMOVE);
    st.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd)
      CMD_LOAD:  rd_addr = fill_m1[AW-1:0];
      CMD_SCAN:  rd_addr = match ? (cidx + AW'(1)) : (cidx - AW'(1));
      CMD_SHIFT: rd_addr = cidx + AW'(2);
      default:   rd_addr = cidx;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cidx;
    wr_data = rd_data;
    if (cmd == CMD_LOAD && in_mode == MODE_ADD && !full) begin
      wr_en   = 1'b1;
      wr_addr = fill[AW-1:0];
      wr_data = in_value;
    end else if (cmd == CMD_SHIFT && !shift_last) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          case (in_mode)
            MODE_ADD:   if (!full) fill <= fill + CW'(1);
            MODE_POP:   if (!empty) fill <= fill_m1;
            MODE_CLEAR: fill <= '0;
            default:    fill <= fill;
          endcase
        end
        CMD_SHIFT: if (shift_last) fill <= fill_m1;
        default:   fill <= fill;
      endcase
      if (cmd == CMD_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        val      <= in_value;
        mode     <= in_mode;
        cidx     <= fill_m1[AW-1:0];
        r_member <= 1'b0;
        r_popped <= '0;
        if (in_mode == MODE_ADD && full) begin
          r_err <= ERR_FULL;
        end else if (in_mode == MODE_POP && empty) begin
          r_err <= ERR_EMPTY;
        end else begin
          r_err <= ERR_NONE;
        end
      end
      CMD_POPCAP: r_popped <= rd_data;
      CMD_SCAN: begin
        if (match) begin
          r_member <= 1'b1;
        end else begin
          cidx <= cidx - AW'(1);
        end
      end
      CMD_SHIFT: if (!shift_last) cidx <= cidx + AW'(1);
      CMD_EMIT: begin
        out_member <= r_member;
        out_popped <= r_popped;
        out_empty  <= empty;
        out_count  <= fill;
        out_error  <= r_err;
      end
      default: ;
    endcase
  end

  a_shift_after_hit: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_SHIFT |-> r_member)
    else $error("shift without a found entry");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LOAD && in_mode == MODE_ADD && !full) |=> fill == $past(fill) + CW'(1))
    else $error("add did not grow the store");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_EMIT |=> (out_valid && out_count == $past(fill)))
    else $error("emitted count differs from fill");

endmodule

[sv/iss_ctrl.sv]
// Controller: sequences load, pop capture, scan, shift and result emission.
// Talks to iss_dp through cmd_t and status_t from iss_pkg.
module iss_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [iss_pkg::MODE_W-1:0]  in_mode,
  input  iss_pkg::status_t            st,
  output iss_pkg::cmd_t               cmd
);
  import iss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:     cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_POP_WAIT: cmd = CMD_POPCAP;
      S_SCAN:     cmd = CMD_SCAN;
      S_SHIFT:    cmd = CMD_SHIFT;
      S_RESULT:   cmd = st.out_free ? CMD_EMIT : CMD_NONE;
      default:    cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_mode == MODE_POP) begin
              state <= st.empty ? S_RESULT : S_POP_WAIT;
            end else if (in_mode inside {MODE_TEST, MODE_REMOVE}) begin
              state <= st.empty ? S_RESULT : S_SCAN;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_POP_WAIT: state <= S_RESULT;
        S_SCAN: begin
          if (st.hit) begin
            state <= st.remove ? S_SHIFT : S_RESULT;
          end else if (st.scan_last) begin
            state <= S_RESULT;
          end
        end
        S_SHIFT:  if (st.shift_last) state <= S_RESULT;
        S_RESULT: if (st.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_hit_remove_shifts: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && st.hit && st.remove) |=> state == S_SHIFT)
    else $error("remove hit did not start the shift");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

[sv/int_set_stack_with_search.sv]
// Top level of the integer set stack with search; joins iss_ctrl and iss_dp.
// Depends on iss_pkg, iss_req_if and iss_rsp_if.
//
// One request transaction gives one response transaction. Items are handled one at a
// time through a value memory with one write port and one registered read port, one
// entry per cycle.
// From request to response valid: add, clear and unused codes pass load and result;
// pop adds pop capture (skipped when empty); test adds a scan of the entries from the
// newest down (at most the count); remove on a hit also shifts the entries above it
// down, one entry a cycle. A new request is taken once the previous response is
// registered, even while it still waits on the sink; the new response is then held
// back until the sink takes the previous one. The store is empty after reset.
module int_set_stack_with_search #(
  parameter int DEPTH = iss_pkg::DEPTH_DEF
) (
  input logic             clk,
  input logic             rst,
  iss_req_if.sink         req,
  iss_rsp_if.source       rsp
);
  import iss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t    cmd;
  status_t st;

  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_mode  (req.mode),
    .st       (st),
    .cmd      (cmd)
  );

  iss_dp #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .in_mode    (req.mode),
    .in_value   (req.value),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_member (rsp.is_member),
    .out_popped (rsp.popped_value),
    .out_empty  (rsp.now_empty),
    .out_count  (rsp.entry_count),
    .out_error  (rsp.error_code)
  );

endmodule
